[src/lrt_pkg.sv]
package lrt_pkg;

	// Default sizing
	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int ITEM_KEY_W = 32;
	localparam int STATUS_W   = 2;
	localparam int HIT_W      = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCESS = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPLIED = 2'd0,
		ST_NONE    = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // latch the incoming transaction
		logic clear;   // empty the table, zero the hit counter
		logic issue;   // read one slot and advance the sweep address
		logic update;  // sweep is the rank update pass (else the match scan)
		logic commit;  // apply bookkeeping and load the result register
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic addr_last;  // sweep address is on the last slot
		logic out_free;   // result register can take a new result
	} sts_t;

endpackage

[src/lru_replacement_tracker.sv]
// LRU replacement tracker: holds up to ENTRIES distinct keys in recency order.
// Each input transaction carries an operation (access, add, remove, clear) and
// a key; each yields exactly one result with the status, the least recently
// used key as eviction victim, the occupancy and the hit count, all taken after
// the operation. Keys and ranks live in two small RAMs and are swept one slot a
// cycle: a match scan over all slots, then a rank update pass that also finds
// the victim. The result is registered after the update pass, or after the
// clearing step for a clear; the next item can be accepted the cycle after
// the result is registered. Registering a result waits while the result
// register holds one that the output has not yet taken.
// The block works on one item at a time. An add to a full table is refused with
// status 2. The result register lets the next item be taken while the previous
// result waits on the output. No clearing pass is needed after reset.
module lru_replacement_tracker #(
	parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[1:0], item_key[33:2], zero fill [39:34]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], victim_valid[2], victim_key[34:3], item_count, hit_count, zero fill
	output logic [((67 + $clog2(ENTRIES+1) + 7) / 8) * 8 - 1:0] m_tdata
);

	import lrt_pkg::*;

	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int OUT_BITS = STATUS_W + 1 + ITEM_KEY_W + CNT_W + HIT_W;
	localparam int CNT_LO   = STATUS_W + 1 + ITEM_KEY_W;
	localparam int HIT_LO   = CNT_LO + CNT_W;

	ctl_t                  ctl;
	sts_t                  sts;
	cmd_t                  in_cmd;
	status_t               out_status;
	logic                  out_victim_valid;
	logic [ITEM_KEY_W-1:0] out_victim_key;
	logic [CNT_W-1:0]      out_count;
	logic [HIT_W-1:0]      out_hits;

	assign in_cmd = cmd_t'(s_tdata[CMD_W-1:0]);

	lrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (in_cmd),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lrt_datapath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.in_cmd           (in_cmd),
		.in_key           (s_tdata[CMD_W +: ITEM_KEY_W]),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_status       (out_status),
		.out_victim_valid (out_victim_valid),
		.out_victim_key   (out_victim_key),
		.out_count        (out_count),
		.out_hits         (out_hits)
	);

	// Result packing
	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_BITS-1:0] = {out_hits, out_count, out_victim_key,
			out_victim_valid, out_status};
	end

	// One item in flight: no second acceptance right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Occupancy never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[HIT_LO-1:CNT_LO] <= CNT_W'(ENTRIES)))
		else $error("occupancy above table size");

	// Victim is flagged exactly when the table is not empty
	a_victim_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STATUS_W] == (m_tdata[HIT_LO-1:CNT_LO] != '0)))
		else $error("victim flag disagrees with occupancy");

	// A full-table refusal only happens with the table full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[STATUS_W-1:0] == ST_FULL))
			|-> (m_tdata[HIT_LO-1:CNT_LO] == CNT_W'(ENTRIES)))
		else $error("add refused while table has room");

endmodule

[src/lrt_ram.sv]
module lrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/lrt_ctrl.sv]
module lrt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  lrt_pkg::cmd_t in_cmd,
	output logic          in_ready,
	input  lrt_pkg::sts_t sts,
	output lrt_pkg::ctl_t ctl
);

	import lrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLR,
		S_SCAN,
		S_SCAN_END,
		S_UPD,
		S_UPD_END,
		S_DONE
	} state_t;

	state_t state_q;

	// Next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_cmd == CMD_CLEAR) ? S_CLR : S_SCAN;
					end
				end
				S_CLR:      state_q <= S_DONE;
				S_SCAN: begin
					if (sts.addr_last) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: state_q <= S_UPD;
				S_UPD: begin
					if (sts.addr_last) begin
						state_q <= S_UPD_END;
					end
				end
				S_UPD_END:  state_q <= S_DONE;
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		ctl        = '0;
		ctl.load   = (state_q == S_IDLE) && in_valid;
		ctl.clear  = (state_q == S_CLR);
		ctl.issue  = (state_q == S_SCAN) || (state_q == S_UPD);
		ctl.update = (state_q == S_UPD);
		ctl.commit = (state_q == S_DONE) && sts.out_free;
	end

endmodule

[src/lrt_datapath.sv]
module lrt_datapath #(
	parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrt_pkg::ctl_t                       ctl,
	output lrt_pkg::sts_t                       sts,
	input  lrt_pkg::cmd_t                       in_cmd,
	input  logic [lrt_pkg::ITEM_KEY_W-1:0]      in_key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lrt_pkg::status_t                    out_status,
	output logic                                out_victim_valid,
	output logic [lrt_pkg::ITEM_KEY_W-1:0]      out_victim_key,
	output logic [$clog2(ENTRIES+1)-1:0]        out_count,
	output logic [lrt_pkg::HIT_W-1:0]           out_hits
);

	import lrt_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Transaction registers
	cmd_t                 cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [KEY_BITS-1:0]  key_ext;

	// Sweep address and read pipeline stage
	logic [IDX_W-1:0]     addr_q;
	logic                 proc_s1;
	logic                 upd_s1;
	logic [IDX_W-1:0]     idx_s1;

	// Scan results
	logic                 found_q;
	logic [IDX_W-1:0]     slot_q;
	logic [IDX_W-1:0]     rank_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_slot_q;

	// Victim search
	logic                 victim_found_q;
	logic [KEY_BITS-1:0]  victim_q;

	// Table bookkeeping
	logic [ENTRIES-1:0]   valid_q;
	logic [CNT_W-1:0]     occ_q;
	logic [HIT_W-1:0]     hits_q;

	// RAM ports
	logic [KEY_BITS-1:0]  key_rd;
	logic [IDX_W-1:0]     rank_rd;
	logic                 key_we;
	logic                 rank_we;
	logic [IDX_W-1:0]     rank_new;

	// Decision and per-slot terms
	logic                 acc_apply;
	logic                 add_full;
	logic                 add_apply;
	logic                 rem_apply;
	status_t              status_c;
	logic [CNT_W-1:0]     occ_new;
	logic [CNT_W-1:0]     occ_m1;
	logic [IDX_W-1:0]     target;
	logic [HIT_W-1:0]     hits_new;
	logic                 ent_v;
	logic                 is_slot;
	logic                 is_new;
	logic                 live;
	logic [KEY_BITS-1:0]  cand_key;
	logic [ITEM_KEY_W-1:0] victim32;

	lrt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (idx_s1),
		.wr_data (key_q),
		.rd_en   (ctl.issue),
		.rd_addr (addr_q),
		.rd_data (key_rd)
	);

	lrt_ram #(
		.WIDTH (IDX_W),
		.DEPTH (ENTRIES)
	) u_rank_ram (
		.clk     (clk),
		.wr_en   (rank_we),
		.wr_addr (idx_s1),
		.wr_data (rank_new),
		.rd_en   (ctl.issue),
		.rd_addr (addr_q),
		.rd_data (rank_rd)
	);

	// Incoming key on KEY_BITS bits, upper bits zero beyond the field
	always_comb begin
		for (int b = 0; b < KEY_BITS; b++) begin
			key_ext[b] = (b < ITEM_KEY_W) ? in_key[b] : 1'b0;
		end
	end

	// Victim key trimmed to the result field
	always_comb begin
		for (int b = 0; b < ITEM_KEY_W; b++) begin
			victim32[b] = (b < KEY_BITS) ? victim_q[b] : 1'b0;
		end
	end

	// Operation outcome from the scan results
	always_comb begin
		acc_apply = (cmd_q == CMD_ACCESS) && found_q;
		add_full  = (cmd_q == CMD_ADD) && !found_q
			&& ((occ_q >= CNT_W'(ENTRIES)) || !free_found_q);
		add_apply = (cmd_q == CMD_ADD) && !found_q && !add_full;
		rem_apply = (cmd_q == CMD_REMOVE) && found_q;

		if (cmd_q == CMD_CLEAR || acc_apply || add_apply || rem_apply) begin
			status_c = ST_APPLIED;
		end else if (add_full) begin
			status_c = ST_FULL;
		end else begin
			status_c = ST_NONE;
		end

		if (add_apply) begin
			occ_new = occ_q + CNT_W'(1);
		end else if (rem_apply) begin
			occ_new = occ_q - CNT_W'(1);
		end else begin
			occ_new = occ_q;
		end
		occ_m1   = occ_new - CNT_W'(1);
		target   = occ_m1[IDX_W-1:0];
		hits_new = hits_q + {{(HIT_W-1){1'b0}}, acc_apply};
	end

	// New rank of the slot coming out of the RAMs
	always_comb begin
		ent_v    = valid_q[idx_s1];
		is_slot  = found_q && (idx_s1 == slot_q);
		is_new   = add_apply && (idx_s1 == free_slot_q);
		live     = (ent_v && !(rem_apply && is_slot)) || is_new;
		cand_key = is_new ? key_q : key_rd;

		if (is_new) begin
			rank_new = '0;
		end else if (acc_apply) begin
			if (is_slot) begin
				rank_new = '0;
			end else if (rank_rd < rank_q) begin
				rank_new = rank_rd + IDX_W'(1);
			end else begin
				rank_new = rank_rd;
			end
		end else if (add_apply) begin
			rank_new = rank_rd + IDX_W'(1);
		end else if (rem_apply && (rank_rd > rank_q)) begin
			rank_new = rank_rd - IDX_W'(1);
		end else begin
			rank_new = rank_rd;
		end

		rank_we = proc_s1 && upd_s1 && (ent_v || is_new);
		key_we  = proc_s1 && upd_s1 && is_new;
	end

	assign sts.addr_last = (addr_q == IDX_W'(ENTRIES - 1));
	assign sts.out_free  = !out_valid || out_ready;

	// Transaction latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_cmd;
			key_q <= key_ext;
		end
	end

	// Sweep address and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			proc_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			proc_s1 <= ctl.issue;
			upd_s1  <= ctl.update;
			if (ctl.load) begin
				addr_q <= '0;
			end else if (ctl.issue) begin
				addr_q <= sts.addr_last ? '0 : addr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	// Scan: key match and lowest free slot; update: victim search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			victim_found_q <= 1'b0;
		end else if (ctl.load) begin
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			victim_found_q <= 1'b0;
		end else if (proc_s1 && !upd_s1) begin
			if (ent_v && (key_rd == key_q)) begin
				found_q <= 1'b1;
			end
			if (!ent_v && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end else if (proc_s1 && upd_s1) begin
			if (live && (rank_new == target)) begin
				victim_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && !upd_s1) begin
			if (ent_v && (key_rd == key_q)) begin
				slot_q <= idx_s1;
				rank_q <= rank_rd;
			end
			if (!ent_v && !free_found_q) begin
				free_slot_q <= idx_s1;
			end
		end
		if (proc_s1 && upd_s1 && live && (rank_new == target)) begin
			victim_q <= cand_key;
		end
	end

	// Table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			hits_q  <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
			occ_q   <= '0;
			hits_q  <= '0;
		end else if (ctl.commit) begin
			occ_q  <= occ_new;
			hits_q <= hits_new;
			if (add_apply) begin
				valid_q[free_slot_q] <= 1'b1;
			end
			if (rem_apply) begin
				valid_q[slot_q] <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_status       <= status_c;
			out_victim_valid <= (occ_new != '0);
			out_victim_key   <= ((occ_new != '0) && victim_found_q) ? victim32 : '0;
			out_count        <= occ_new;
			out_hits         <= hits_new;
		end
	end

endmodule
